### rtl/core/lir_pkg.sv
// shared types and constants for the linear interpolation resampler
package lir_pkg;

  localparam int SampleW = 16;
  localparam int FracW   = 8;
  localparam int PosW    = 40;
  localparam int FrameW  = 32;
  localparam int DoneW   = 24;
  localparam int StepW   = 16;
  localparam int ChanW   = 2;
  localparam int CfgW    = 24;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_STEP  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CHAN  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WIDE  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_COUNT = 2'd3;

  localparam logic [ChanW-1:0] CHAN_STEREO = 2'd2;

  localparam logic signed [SampleW-1:0] NARROW_OFFSET = 16'sd128;

  localparam logic [StepW-1:0] STEP_RESET = 16'd256;
  localparam logic [ChanW-1:0] CHAN_RESET = 2'd1;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_left;
    logic signed [SampleW-1:0] sample_right;
    logic                      final_frame;
  } lir_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] out_left;
    logic signed [SampleW-1:0] out_right;
    logic                      run_end;
  } lir_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPAN,
    ST_TAIL,
    ST_FLUSH
  } lir_state_e;

endpackage

### rtl/core/linear_interp_resampler.sv
// top level of the linear interpolation sample rate converter
// Each request carries one mono or stereo source frame. The block emits each output
// frame whose 32.8 position lies on the previous frame, up to MAX_OUTPUTS_PER_FRAME
// per frame and the configured count in all, one output per cycle while the output
// is not stalled, through a pair of blend lanes (left and right) that share one
// fraction. A frame takes the request, emits its outputs, closes the span and
// releases the last output marked run_end. Results pass a hold and an output register;
// a stalled output holds the block back. A frame marked final also emits the tail
// toward silence and then clears the run state. Configuration writes take effect at
// once and belong between sounds or while the block is idle.
module linear_interp_resampler #(
  parameter int MAX_OUTPUTS_PER_FRAME = 16,
  parameter int SAMPLE_BITS           = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lir_pkg::lir_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lir_pkg::lir_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [lir_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lir_pkg::CfgW-1:0]      cfg_data_i
);
  import lir_pkg::*;

  localparam int CntW = $clog2(MAX_OUTPUTS_PER_FRAME + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_OUTPUTS_PER_FRAME);

  function automatic logic signed [SampleW-1:0] decode(input logic [SampleW-1:0] raw,
                                                       input logic wide);
    logic signed [SampleW-1:0] w;
    logic signed [SampleW-1:0] n;
    w = SampleW'($signed(raw[SAMPLE_BITS-1:0]));
    n = $signed({{(SampleW-8){1'b0}}, raw[7:0]}) - NARROW_OFFSET;
    return wide ? w : n;
  endfunction

  // configuration
  logic [StepW-1:0] step_q;
  logic [ChanW-1:0] chan_q;
  logic             wide_q;
  logic [DoneW-1:0] count_q;

  // run state
  lir_state_e               state_q, state_d;
  logic signed [SampleW-1:0] prev_l_q, prev_l_d, prev_r_q, prev_r_d;
  logic signed [SampleW-1:0] cur_l_q, cur_l_d, cur_r_q, cur_r_d;
  logic                     fin_q, fin_d;
  logic                     have_prev_q, have_prev_d;
  logic [FrameW-1:0]        frame_q, frame_d;
  logic [PosW-1:0]          pos_q, pos_d;
  logic [DoneW-1:0]         done_q, done_d;
  logic [CntW-1:0]          cnt_q, cnt_d;

  // merge stage and output register
  logic     hold_valid_q, hold_valid_d;
  lir_out_t hold_q, hold_d;
  logic     out_valid_q, out_valid_d;
  lir_out_t out_q, out_d;
  logic     out_push;
  lir_out_t out_payload;

  logic                      stereo;
  logic signed [SampleW-1:0] dec_l, dec_r;
  logic signed [SampleW-1:0] b_l, b_r;
  logic signed [SampleW-1:0] lane_l, lane_r;
  logic [FrameW-1:0]         ahead;
  logic                      step_ok;
  logic                      can_move;
  lir_out_t                  res;

  assign stereo   = (chan_q == CHAN_STEREO);
  assign dec_l    = decode(in_data_i.sample_left, wide_q);
  assign dec_r    = stereo ? decode(in_data_i.sample_right, wide_q) : '0;
  assign b_l      = (state_q == ST_TAIL) ? '0 : cur_l_q;
  assign b_r      = (state_q == ST_TAIL) ? '0 : cur_r_q;
  assign ahead    = pos_q[PosW-1:FracW] - frame_q;
  assign step_ok  = (cnt_q < CntMax) && (done_q < count_q) &&
                    ((ahead == '0) || ahead[FrameW-1]);
  assign can_move = !out_valid_q || out_ready_i;

  lir_lane u_lane_left (
    .a_i   (prev_l_q),
    .b_i   (b_l),
    .frac_i(pos_q[FracW-1:0]),
    .y_o   (lane_l)
  );

  lir_lane u_lane_right (
    .a_i   (prev_r_q),
    .b_i   (b_r),
    .frac_i(pos_q[FracW-1:0]),
    .y_o   (lane_r)
  );

  always_comb begin
    res.out_left  = lane_l;
    res.out_right = stereo ? lane_r : '0;
    res.run_end   = 1'b0;
  end

  always_comb begin
    state_d      = state_q;
    prev_l_d     = prev_l_q;
    prev_r_d     = prev_r_q;
    cur_l_d      = cur_l_q;
    cur_r_d      = cur_r_q;
    fin_d        = fin_q;
    have_prev_d  = have_prev_q;
    frame_d      = frame_q;
    pos_d        = pos_q;
    done_d       = done_q;
    cnt_d        = cnt_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    out_push     = 1'b0;
    out_payload  = hold_q;
    in_ready_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cur_l_d = dec_l;
          cur_r_d = dec_r;
          fin_d   = in_data_i.final_frame;
          cnt_d   = '0;
          if (have_prev_q) begin
            state_d = ST_SPAN;
          end else begin
            prev_l_d    = dec_l;
            prev_r_d    = dec_r;
            have_prev_d = 1'b1;
            if (in_data_i.final_frame) begin
              state_d = ST_TAIL;
            end
          end
        end
      end
      ST_SPAN, ST_TAIL: begin
        if (step_ok) begin
          if (!hold_valid_q || can_move) begin
            out_push     = hold_valid_q;
            hold_d       = res;
            hold_valid_d = 1'b1;
            cnt_d        = cnt_q + 1'b1;
            done_d       = done_q + 1'b1;
            pos_d        = pos_q + PosW'(step_q);
          end
        end else if (state_q == ST_SPAN) begin
          frame_d     = frame_q + 1'b1;
          prev_l_d    = cur_l_q;
          prev_r_d    = cur_r_q;
          have_prev_d = 1'b1;
          cnt_d       = '0;
          state_d     = fin_q ? ST_TAIL : ST_FLUSH;
        end else begin
          prev_l_d    = '0;
          prev_r_d    = '0;
          have_prev_d = 1'b0;
          frame_d     = '0;
          pos_d       = '0;
          done_d      = '0;
          state_d     = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!hold_valid_q) begin
          state_d = ST_IDLE;
        end else if (can_move) begin
          out_push            = 1'b1;
          out_payload.run_end = 1'b1;
          hold_valid_d        = 1'b0;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_push) begin
      out_d       = out_payload;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_RESET;
      chan_q  <= CHAN_RESET;
      wide_q  <= 1'b1;
      count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEP:  step_q  <= cfg_data_i[StepW-1:0];
        CFG_CHAN:  chan_q  <= cfg_data_i[ChanW-1:0];
        CFG_WIDE:  wide_q  <= cfg_data_i[0];
        CFG_COUNT: count_q <= cfg_data_i[DoneW-1:0];
        default:   step_q  <= step_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      prev_l_q     <= '0;
      prev_r_q     <= '0;
      have_prev_q  <= 1'b0;
      frame_q      <= '0;
      pos_q        <= '0;
      done_q       <= '0;
      cnt_q        <= '0;
      fin_q        <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      prev_l_q     <= prev_l_d;
      prev_r_q     <= prev_r_d;
      have_prev_q  <= have_prev_d;
      frame_q      <= frame_d;
      pos_q        <= pos_d;
      done_q       <= done_d;
      cnt_q        <= cnt_d;
      fin_q        <= fin_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_l_q <= cur_l_d;
    cur_r_q <= cur_r_d;
    hold_q  <= hold_d;
    out_q   <= out_d;
  end

endmodule

### rtl/core/lir_lane.sv
// one channel lane: blends frame a toward frame b by an 8-bit fraction
module lir_lane (
  input  logic signed [lir_pkg::SampleW-1:0] a_i,
  input  logic signed [lir_pkg::SampleW-1:0] b_i,
  input  logic        [lir_pkg::FracW-1:0]   frac_i,
  output logic signed [lir_pkg::SampleW-1:0] y_o
);
  import lir_pkg::*;

  localparam int DiffW = SampleW + 1;
  localparam int ProdW = DiffW + FracW + 1;

  logic signed [DiffW-1:0] diff;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] shifted;
  logic signed [DiffW-1:0] sum;

  assign diff    = DiffW'(b_i) - DiffW'(a_i);
  assign prod    = ProdW'(diff) * ProdW'($signed({1'b0, frac_i}));
  // arithmetic shift rounds toward minus infinity
  assign shifted = prod >>> FracW;
  assign sum     = DiffW'(a_i) + $signed(shifted[DiffW-1:0]);
  assign y_o     = sum[SampleW-1:0];

endmodule
